@@ src/response_frame_checker_top_defines.svh @@
// Assertion macros used by the response frame checker assertion module.
// No dependencies.
`ifndef RESPONSE_FRAME_CHECKER_TOP_DEFINES_SVH
`define RESPONSE_FRAME_CHECKER_TOP_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define RFC_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error("rfc assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define RFC_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error("rfc assertion failed");

`endif

@@ src/rfc_pkg.sv @@
// Response frame checker package: types, codes and frame constants.
// No dependencies; used by every RTL file of the block.
`default_nettype none

package rfc_pkg;

  localparam int MAX_FRAME_BYTES = 64;
  localparam logic [8:0] MAX_LEN_BYTE = 9'(MAX_FRAME_BYTES - 8);

  localparam logic [7:0] SYNC_ZERO = 8'h00;
  localparam logic [7:0] SYNC_FF   = 8'hFF;
  localparam logic [7:0] FRAME_ID  = 8'hD5;
  localparam logic [7:0] MIN_LEN   = 8'h02;

  localparam int APB_AW = 3;
  localparam int APB_DW = 32;

  typedef enum logic [0:0] {
    REG_EXP_CMD  = 1'b0,
    REG_CAPACITY = 1'b1
  } rfc_reg_e;

  typedef enum logic [2:0] {
    STS_OK        = 3'd0,
    STS_NOT_READY = 3'd1,
    STS_BAD_HDR   = 3'd2,
    STS_TOO_LONG  = 3'd3,
    STS_BAD_LCS   = 3'd4,
    STS_BAD_ID    = 3'd5,
    STS_TOO_LARGE = 3'd6,
    STS_BAD_DCS   = 3'd7
  } rfc_status_e;

  typedef enum logic [9:0] {
    PH_IDLE   = 10'b00_0000_0001,
    PH_SYNC0  = 10'b00_0000_0010,
    PH_SYNC1  = 10'b00_0000_0100,
    PH_SYNCFF = 10'b00_0000_1000,
    PH_LEN    = 10'b00_0001_0000,
    PH_LCS    = 10'b00_0010_0000,
    PH_TFI    = 10'b00_0100_0000,
    PH_CMD    = 10'b00_1000_0000,
    PH_DATA   = 10'b01_0000_0000,
    PH_DCS    = 10'b10_0000_0000
  } rfc_phase_e;

  typedef struct packed {
    logic [7:0] expected_command;
    logic [7:0] receive_capacity;
  } rfc_cfg_t;

  typedef struct packed {
    logic [7:0]  payload_byte;
    logic        is_payload;
    logic        last;
    rfc_status_e status;
  } rfc_result_t;

endpackage

`default_nettype wire

@@ src/rfc_if.sv @@
// Stream interfaces of the response frame checker: byte input and result output.
// Depends on rfc_pkg.
`default_nettype none

interface rfc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;
  logic       frame_start;

  modport source (output valid, output rx_byte, output frame_start, input ready);
  modport sink   (input valid, input rx_byte, input frame_start, output ready);
endinterface

interface rfc_out_if;
  logic                 valid;
  logic                 ready;
  logic [7:0]           payload_byte;
  logic                 is_payload;
  logic                 last;
  rfc_pkg::rfc_status_e status;

  modport source (output valid, output payload_byte, output is_payload, output last,
                  output status, input ready);
  modport sink   (input valid, input payload_byte, input is_payload, input last,
                  input status, output ready);
endinterface

`default_nettype wire

@@ src/response_frame_checker_top.sv @@
// Top level of the response frame checker: APB registers and frame datapath.
// Depends on rfc_pkg, rfc_if, rfc_regs and rfc_core.
`default_nettype none

// Checks a reader controller response frame one byte per transfer, starting at
// the status byte (frame_start set). Payload bytes are forwarded as they arrive;
// each frame not cut short by a new frame_start ends in one result with last set
// and a status code, and the payload must be dropped unless that status is ok.
// Bytes outside a frame produce nothing. Throughput is one byte per clock while
// out_o does not stall. A byte taken sits in the input register, and its result
// is loaded from there into the result register, whose contents drive out_o.
// in_i.ready drops only while the input register holds a byte and a result waits
// on out_o; it then follows out_o.ready within the same cycle. Registers: 0x0
// expected command, 0x4 receive capacity; write them only while no frame is in
// flight.
module response_frame_checker_top (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  rfc_in_if.sink                          in_i,
  rfc_out_if.source                       out_o,
  input  wire logic                       psel_i,
  input  wire logic                       penable_i,
  input  wire logic                       pwrite_i,
  input  wire logic [rfc_pkg::APB_AW-1:0] paddr_i,
  input  wire logic [rfc_pkg::APB_DW-1:0] pwdata_i,
  output logic      [rfc_pkg::APB_DW-1:0] prdata_o,
  output logic                            pready_o
);

  rfc_pkg::rfc_cfg_t    cfg;
  rfc_pkg::rfc_result_t res;

  rfc_regs u_regs (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .psel_i    (psel_i),
    .penable_i (penable_i),
    .pwrite_i  (pwrite_i),
    .paddr_i   (paddr_i),
    .pwdata_i  (pwdata_i),
    .prdata_o  (prdata_o),
    .pready_o  (pready_o),
    .cfg_o     (cfg)
  );

  rfc_core u_core (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg),
    .in_valid_i    (in_i.valid),
    .in_ready_o    (in_i.ready),
    .rx_byte_i     (in_i.rx_byte),
    .frame_start_i (in_i.frame_start),
    .out_valid_o   (out_o.valid),
    .out_ready_i   (out_o.ready),
    .out_o         (res)
  );

  assign out_o.payload_byte = res.payload_byte;
  assign out_o.is_payload   = res.is_payload;
  assign out_o.last         = res.last;
  assign out_o.status       = res.status;

endmodule

`default_nettype wire

@@ src/rfc_regs.sv @@
// APB configuration registers: expected command and receive capacity.
// Depends on rfc_pkg.
`default_nettype none

module rfc_regs (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       psel_i,
  input  wire logic                       penable_i,
  input  wire logic                       pwrite_i,
  input  wire logic [rfc_pkg::APB_AW-1:0] paddr_i,
  input  wire logic [rfc_pkg::APB_DW-1:0] pwdata_i,
  output logic      [rfc_pkg::APB_DW-1:0] prdata_o,
  output logic                            pready_o,
  output rfc_pkg::rfc_cfg_t               cfg_o
);

  rfc_pkg::rfc_cfg_t cfg_q, cfg_d;
  rfc_pkg::rfc_reg_e reg_sel;
  logic              wr_en;

  assign reg_sel  = rfc_pkg::rfc_reg_e'(paddr_i[2]);
  assign wr_en    = psel_i && penable_i && pwrite_i && pready_o;
  assign pready_o = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      unique case (reg_sel)
        rfc_pkg::REG_EXP_CMD:  cfg_d.expected_command = pwdata_i[7:0];
        rfc_pkg::REG_CAPACITY: cfg_d.receive_capacity = pwdata_i[7:0];
        default: cfg_d = cfg_q;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      rfc_pkg::REG_EXP_CMD:  prdata_o = {24'd0, cfg_q.expected_command};
      rfc_pkg::REG_CAPACITY: prdata_o = {24'd0, cfg_q.receive_capacity};
      default:               prdata_o = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.expected_command <= 8'h00;
      cfg_q.receive_capacity <= 8'hFF;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

@@ src/rfc_core.sv @@
// Frame checker datapath: input register, frame state machine, result register.
// Depends on rfc_pkg.
`default_nettype none

module rfc_core (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire rfc_pkg::rfc_cfg_t    cfg_i,
  input  wire logic                 in_valid_i,
  output logic                      in_ready_o,
  input  wire logic [7:0]           rx_byte_i,
  input  wire logic                 frame_start_i,
  output logic                      out_valid_o,
  input  wire logic                 out_ready_i,
  output rfc_pkg::rfc_result_t      out_o
);

  logic                 s1_valid_q;
  logic [7:0]           s1_byte_q;
  logic                 s1_start_q;
  logic                 advance;

  rfc_pkg::rfc_phase_e  phase_q, phase_d;
  logic [7:0]           len_q, len_d;
  logic [7:0]           left_q, left_d;
  logic [7:0]           sum_q, sum_d;
  logic [7:0]           sum_add;
  logic [7:0]           len_minus2;
  logic [7:0]           echo;
  logic [7:0]           left_dec;

  logic                 res_valid;
  rfc_pkg::rfc_result_t res;
  logic                 out_valid_q;
  rfc_pkg::rfc_result_t out_q;

  assign advance    = s1_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !s1_valid_q || advance;

  assign sum_add    = sum_q + s1_byte_q;
  assign len_minus2 = len_q - rfc_pkg::MIN_LEN;
  assign echo       = cfg_i.expected_command + 8'd1;
  assign left_dec   = left_q - 8'd1;

  always_comb begin
    phase_d   = phase_q;
    len_d     = len_q;
    left_d    = left_q;
    sum_d     = sum_q;
    res_valid = 1'b0;
    res       = '{payload_byte: 8'h00, is_payload: 1'b0, last: 1'b1,
                  status: rfc_pkg::STS_OK};
    if (s1_start_q) begin
      len_d  = 8'h00;
      left_d = 8'h00;
      sum_d  = 8'h00;
      if (!s1_byte_q[0]) begin
        res_valid  = 1'b1;
        res.status = rfc_pkg::STS_NOT_READY;
        phase_d    = rfc_pkg::PH_IDLE;
      end else begin
        phase_d = rfc_pkg::PH_SYNC0;
      end
    end else begin
      unique case (phase_q)
        rfc_pkg::PH_IDLE: ;
        rfc_pkg::PH_SYNC0, rfc_pkg::PH_SYNC1: begin
          if (s1_byte_q != rfc_pkg::SYNC_ZERO) begin
            res_valid  = 1'b1;
            res.status = rfc_pkg::STS_BAD_HDR;
            phase_d    = rfc_pkg::PH_IDLE;
          end else begin
            phase_d = (phase_q == rfc_pkg::PH_SYNC0) ? rfc_pkg::PH_SYNC1
                                                     : rfc_pkg::PH_SYNCFF;
          end
        end
        rfc_pkg::PH_SYNCFF: begin
          if (s1_byte_q != rfc_pkg::SYNC_FF) begin
            res_valid  = 1'b1;
            res.status = rfc_pkg::STS_BAD_HDR;
            phase_d    = rfc_pkg::PH_IDLE;
          end else begin
            phase_d = rfc_pkg::PH_LEN;
          end
        end
        rfc_pkg::PH_LEN: begin
          if ({1'b0, s1_byte_q} > rfc_pkg::MAX_LEN_BYTE) begin
            res_valid  = 1'b1;
            res.status = rfc_pkg::STS_TOO_LONG;
            phase_d    = rfc_pkg::PH_IDLE;
          end else if (s1_byte_q < rfc_pkg::MIN_LEN) begin
            res_valid  = 1'b1;
            res.status = rfc_pkg::STS_BAD_HDR;
            phase_d    = rfc_pkg::PH_IDLE;
          end else begin
            len_d   = s1_byte_q;
            phase_d = rfc_pkg::PH_LCS;
          end
        end
        rfc_pkg::PH_LCS: begin
          if ((len_q + s1_byte_q) != 8'h00) begin
            res_valid  = 1'b1;
            res.status = rfc_pkg::STS_BAD_LCS;
            phase_d    = rfc_pkg::PH_IDLE;
          end else begin
            phase_d = rfc_pkg::PH_TFI;
          end
        end
        rfc_pkg::PH_TFI: begin
          if (s1_byte_q != rfc_pkg::FRAME_ID) begin
            res_valid  = 1'b1;
            res.status = rfc_pkg::STS_BAD_ID;
            phase_d    = rfc_pkg::PH_IDLE;
          end else begin
            sum_d   = rfc_pkg::FRAME_ID;
            phase_d = rfc_pkg::PH_CMD;
          end
        end
        rfc_pkg::PH_CMD: begin
          if (s1_byte_q != echo) begin
            res_valid  = 1'b1;
            res.status = rfc_pkg::STS_BAD_ID;
            phase_d    = rfc_pkg::PH_IDLE;
          end else begin
            left_d = len_minus2;
            if (len_minus2 > cfg_i.receive_capacity) begin
              res_valid  = 1'b1;
              res.status = rfc_pkg::STS_TOO_LARGE;
              phase_d    = rfc_pkg::PH_IDLE;
            end else begin
              sum_d   = sum_add;
              phase_d = (len_minus2 != 8'h00) ? rfc_pkg::PH_DATA : rfc_pkg::PH_DCS;
            end
          end
        end
        rfc_pkg::PH_DATA: begin
          sum_d            = sum_add;
          left_d           = left_dec;
          res_valid        = 1'b1;
          res.payload_byte = s1_byte_q;
          res.is_payload   = 1'b1;
          res.last         = 1'b0;
          if (left_dec == 8'h00) begin
            phase_d = rfc_pkg::PH_DCS;
          end
        end
        rfc_pkg::PH_DCS: begin
          res_valid  = 1'b1;
          res.status = (sum_add == 8'h00) ? rfc_pkg::STS_OK : rfc_pkg::STS_BAD_DCS;
          phase_d    = rfc_pkg::PH_IDLE;
        end
        default: phase_d = rfc_pkg::PH_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      phase_q     <= rfc_pkg::PH_IDLE;
      len_q       <= 8'h00;
      left_q      <= 8'h00;
      sum_q       <= 8'h00;
    end else begin
      if (in_ready_o) begin
        s1_valid_q <= in_valid_i;
      end
      if (advance) begin
        phase_q <= phase_d;
        len_q   <= len_d;
        left_q  <= left_d;
        sum_q   <= sum_d;
      end
      if (advance && res_valid) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      s1_byte_q  <= rx_byte_i;
      s1_start_q <= frame_start_i;
    end
    if (advance && res_valid) begin
      out_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

endmodule

`default_nettype wire

@@ src/response_frame_checker_checker.sv @@
// Port-level assertions for the response frame checker, bound to the top level.
// Depends on rfc_pkg and response_frame_checker_top_defines.svh.
`default_nettype none
`include "response_frame_checker_top_defines.svh"

module response_frame_checker_checker (
  input wire logic                 clk_i,
  input wire logic                 rst_ni,
  input wire logic                 out_valid_i,
  input wire logic                 out_ready_i,
  input wire logic [7:0]           out_payload_byte_i,
  input wire logic                 out_is_payload_i,
  input wire logic                 out_last_i,
  input wire rfc_pkg::rfc_status_e out_status_i,
  input wire logic                 pready_i
);

  logic pay_fmt_ok;
  logic sts_fmt_ok;

  assign pay_fmt_ok = !out_last_i && (out_status_i == rfc_pkg::STS_OK);
  assign sts_fmt_ok = out_last_i && (out_payload_byte_i == 8'h00);

  `RFC_ASSERT_NXT(a_out_hold, clk_i, rst_ni, out_valid_i && !out_ready_i, out_valid_i)
  `RFC_ASSERT_IMP(a_payload_fmt, clk_i, rst_ni, out_valid_i && out_is_payload_i, pay_fmt_ok)
  `RFC_ASSERT_IMP(a_status_fmt, clk_i, rst_ni, out_valid_i && !out_is_payload_i, sts_fmt_ok)
  `RFC_ASSERT_IMP(a_pready, clk_i, rst_ni, 1'b1, pready_i)

endmodule

bind response_frame_checker_top response_frame_checker_checker u_checker (
  .clk_i              (clk_i),
  .rst_ni             (rst_ni),
  .out_valid_i        (out_o.valid),
  .out_ready_i        (out_o.ready),
  .out_payload_byte_i (out_o.payload_byte),
  .out_is_payload_i   (out_o.is_payload),
  .out_last_i         (out_o.last),
  .out_status_i       (out_o.status),
  .pready_i           (pready_o)
);

`default_nettype wire

@@ test/tb.sv @@
// Testbench for response_frame_checker_top: directed frames, then random frames with errors.
// Predicts results or takes them from a table; checks the stream; drives APB registers.
// Depends on rfc_pkg, rfc_if and the RTL of the block.
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import rfc_pkg::*;

  localparam int LIMIT       = 500000;
  localparam int HOLD_CYCLES = 200;
  localparam int LEN_CEIL    = MAX_FRAME_BYTES - 8;
  localparam int PAY_CEIL    = LEN_CEIL - 2;
  localparam int PHASE_ITEMS = 250;
  localparam rfc_result_t NO_RES = '0;

  typedef struct {
    logic [7:0]  data;
    logic        sof;
    bit          known;
    rfc_result_t want;
  } stim_row_t;

  typedef enum int {
    FR_GOOD, FR_NOT_READY, FR_BAD_SYNC, FR_TOO_LONG, FR_SHORT_LEN, FR_BAD_LCS,
    FR_BAD_ID, FR_BAD_ECHO, FR_OVER_CAP, FR_BAD_DCS, FR_CUT
  } frame_kind_e;

  logic                clk = 1'b0;
  logic                rst_n;
  logic                psel, penable, pwrite;
  logic [APB_AW-1:0]   paddr;
  logic [APB_DW-1:0]   pwdata;
  logic [APB_DW-1:0]   prdata;
  logic                pready;

  rfc_in_if  byte_if ();
  rfc_out_if res_if ();

  response_frame_checker_top u_top (
    .clk_i     (clk),
    .rst_ni    (rst_n),
    .in_i      (byte_if),
    .out_o     (res_if),
    .psel_i    (psel),
    .penable_i (penable),
    .pwrite_i  (pwrite),
    .paddr_i   (paddr),
    .pwdata_i  (pwdata),
    .prdata_o  (prdata),
    .pready_o  (pready)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // frame checker state as predicted
  logic [7:0]  cfg_cmd  = 8'h00;
  logic [7:0]  cfg_cap  = 8'hFF;
  rfc_phase_e  fr_phase = PH_IDLE;
  logic [7:0]  fr_len   = 8'h00;
  logic [7:0]  fr_left  = 8'h00;
  logic [7:0]  fr_sum   = 8'h00;

  rfc_result_t due_results[$];
  stim_row_t   dir_tbl [26];
  bit          steady     = 1'b0;
  bit          hold_req   = 1'b0;
  int          useful_cnt = 0;
  int          fail_cnt   = 0;
  int          cycle_cnt  = 0;

  function automatic rfc_result_t closing_result(rfc_status_e s);
    rfc_result_t r;
    r = '0;
    r.last = 1'b1;
    r.status = s;
    return r;
  endfunction

  function automatic rfc_result_t stop_frame(rfc_status_e s);
    fr_phase = PH_IDLE;
    return closing_result(s);
  endfunction

  function automatic bit frame_step(input logic [7:0] b, input logic sof,
                                    output rfc_result_t r);
    logic [7:0] echo;
    logic [7:0] t;
    echo = cfg_cmd + 8'd1;
    r = NO_RES;
    if (sof) begin
      fr_len = '0;
      fr_left = '0;
      fr_sum = '0;
      if (!b[0]) begin
        r = stop_frame(STS_NOT_READY);
        return 1'b1;
      end
      fr_phase = PH_SYNC0;
      return 1'b0;
    end
    case (fr_phase)
      PH_SYNC0, PH_SYNC1: begin
        if (b != SYNC_ZERO) begin
          r = stop_frame(STS_BAD_HDR);
          return 1'b1;
        end
        fr_phase = (fr_phase == PH_SYNC0) ? PH_SYNC1 : PH_SYNCFF;
      end
      PH_SYNCFF: begin
        if (b != SYNC_FF) begin
          r = stop_frame(STS_BAD_HDR);
          return 1'b1;
        end
        fr_phase = PH_LEN;
      end
      PH_LEN: begin
        if (int'(b) > LEN_CEIL) begin
          r = stop_frame(STS_TOO_LONG);
          return 1'b1;
        end
        if (b < MIN_LEN) begin
          r = stop_frame(STS_BAD_HDR);
          return 1'b1;
        end
        fr_len = b;
        fr_phase = PH_LCS;
      end
      PH_LCS: begin
        t = fr_len + b;
        if (t != 8'h00) begin
          r = stop_frame(STS_BAD_LCS);
          return 1'b1;
        end
        fr_phase = PH_TFI;
      end
      PH_TFI: begin
        if (b != FRAME_ID) begin
          r = stop_frame(STS_BAD_ID);
          return 1'b1;
        end
        fr_sum = FRAME_ID;
        fr_phase = PH_CMD;
      end
      PH_CMD: begin
        if (b != echo) begin
          r = stop_frame(STS_BAD_ID);
          return 1'b1;
        end
        fr_left = fr_len - 8'd2;
        if (fr_left > cfg_cap) begin
          r = stop_frame(STS_TOO_LARGE);
          return 1'b1;
        end
        fr_sum = fr_sum + b;
        fr_phase = (fr_left != 0) ? PH_DATA : PH_DCS;
      end
      PH_DATA: begin
        fr_sum = fr_sum + b;
        fr_left = fr_left - 8'd1;
        if (fr_left == 0) fr_phase = PH_DCS;
        r.payload_byte = b;
        r.is_payload = 1'b1;
        return 1'b1;
      end
      PH_DCS: begin
        t = fr_sum + b;
        r = stop_frame((t != 8'h00) ? STS_BAD_DCS : STS_OK);
        return 1'b1;
      end
      default: fr_phase = PH_IDLE;
    endcase
    return 1'b0;
  endfunction

  function automatic int pick_gap();
    int r;
    if (steady) return 0;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  task automatic send(input logic [7:0] b, input logic sof, input bit known,
                      input rfc_result_t want);
    int gap;
    bit hit;
    rfc_result_t r;
    gap = pick_gap();
    @(negedge clk);
    if (gap > 0) begin
      byte_if.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    byte_if.valid       <= 1'b1;
    byte_if.rx_byte     <= b;
    byte_if.frame_start <= sof;
    do @(posedge clk); while (!byte_if.ready);
    if (sof || fr_phase != PH_IDLE) useful_cnt++;
    hit = frame_step(b, sof, r);
    if (known) due_results.push_back(want);
    else if (hit) due_results.push_back(r);
  endtask

  task automatic drain();
    @(negedge clk);
    byte_if.valid <= 1'b0;
    while (due_results.size() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  task automatic write_reg(input rfc_reg_e idx, input logic [7:0] val);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= APB_DW'(val);
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (idx == REG_EXP_CMD) cfg_cmd = val;
    else cfg_cap = val;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic random_frame(input bit may_break);
    logic [7:0] fr[$];
    logic [7:0] echo, dsum, b;
    frame_kind_e kind;
    int plen, maxp, cut, n;
    steady = ($urandom_range(0, 4) == 0);
    if (may_break && $urandom_range(0, 19) == 0) begin
      n = $urandom_range(1, 6);
      repeat (n) send(8'($urandom), ($urandom_range(0, 3) == 0), 1'b0, NO_RES);
    end
    if ($urandom_range(0, 99) < 65) kind = FR_GOOD;
    else kind = frame_kind_e'($urandom_range(1, int'(FR_CUT)));
    if (kind == FR_CUT && !may_break) kind = FR_GOOD;
    if (kind == FR_OVER_CAP && cfg_cap >= PAY_CEIL) kind = FR_GOOD;
    maxp = (cfg_cap < PAY_CEIL) ? int'(cfg_cap) : PAY_CEIL;
    if (kind == FR_OVER_CAP) plen = $urandom_range(int'(cfg_cap) + 1, PAY_CEIL);
    else if ($urandom_range(0, 9) < 8) plen = $urandom_range(0, (maxp < 6) ? maxp : 6);
    else plen = $urandom_range(0, maxp);
    echo = cfg_cmd + 8'd1;
    fr = '{{7'($urandom), 1'b1}, SYNC_ZERO, SYNC_ZERO, SYNC_FF, 8'(plen + 2),
           8'(0 - (plen + 2)), FRAME_ID, echo};
    dsum = FRAME_ID + echo;
    repeat (plen) begin
      b = 8'($urandom);
      fr.push_back(b);
      dsum = dsum + b;
    end
    fr.push_back(8'(0) - dsum);
    case (kind)
      FR_NOT_READY: fr[0] = fr[0] & 8'hFE;
      FR_BAD_SYNC: begin
        n = $urandom_range(1, 3);
        fr[n] = fr[n] ^ 8'($urandom_range(1, 255));
      end
      FR_TOO_LONG:
        fr[4] = ($urandom_range(0, 3) == 0) ? 8'(LEN_CEIL + 1)
                                            : 8'($urandom_range(LEN_CEIL + 1, 255));
      FR_SHORT_LEN: fr[4] = 8'($urandom_range(0, 1));
      FR_BAD_LCS:   fr[5] = fr[5] ^ 8'($urandom_range(1, 255));
      FR_BAD_ID:    fr[6] = fr[6] ^ 8'($urandom_range(1, 255));
      FR_BAD_ECHO:  fr[7] = fr[7] ^ 8'($urandom_range(1, 255));
      FR_BAD_DCS:   fr[fr.size() - 1] = fr[fr.size() - 1] ^ 8'($urandom_range(1, 255));
      FR_CUT: begin
        cut = $urandom_range(1, fr.size() - 1);
        while (fr.size() > cut) void'(fr.pop_back());
      end
      default: ;
    endcase
    foreach (fr[i]) send(fr[i], (i == 0), 1'b0, NO_RES);
    if (kind != FR_CUT && $urandom_range(0, 9) < 3) begin
      n = $urandom_range(1, 3);
      repeat (n) send(8'($urandom), 1'b0, 1'b0, NO_RES);
    end
  endtask

  // result sink ready
  initial begin
    int len;
    int hold;
    int r;
    res_if.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        res_if.ready <= 1'b0;
        for (hold = 0; hold < HOLD_CYCLES; hold++) @(negedge clk);
      end else begin
        r = $urandom_range(0, 99);
        if (r < 55) begin
          res_if.ready <= 1'b1;
          len = $urandom_range(1, 6);
        end else if (r < 65) begin
          res_if.ready <= 1'b1;
          len = $urandom_range(20, 80);
        end else if (r < 92) begin
          res_if.ready <= 1'b0;
          len = $urandom_range(1, 3);
        end else begin
          res_if.ready <= 1'b0;
          len = $urandom_range(8, 40);
        end
        repeat (len - 1) @(negedge clk);
      end
    end
  end

  always @(posedge clk) begin : check_results
    rfc_result_t want;
    rfc_result_t got;
    if (rst_n && res_if.valid && res_if.ready) begin
      got.payload_byte = res_if.payload_byte;
      got.is_payload   = res_if.is_payload;
      got.last         = res_if.last;
      got.status       = res_if.status;
      if (due_results.size() == 0) begin
        fail_cnt++;
        if (fail_cnt <= 10)
          $display("%0t: unexpected result byte=%02h pay=%0b last=%0b sts=%0d", $realtime,
                   got.payload_byte, got.is_payload, got.last, got.status);
      end else begin
        want = due_results.pop_front();
        if (got.payload_byte !== want.payload_byte || got.is_payload !== want.is_payload ||
            got.last !== want.last || got.status !== want.status) begin
          fail_cnt++;
          if (fail_cnt <= 10)
            $display("%0t: mismatch want byte=%02h pay=%0b last=%0b sts=%0d, got byte=%02h pay=%0b last=%0b sts=%0d",
                     $realtime, want.payload_byte, want.is_payload, want.last, want.status,
                     got.payload_byte, got.is_payload, got.last, got.status);
        end
      end
    end
  end

  initial begin
    while (cycle_cnt < LIMIT) begin
      @(posedge clk);
      cycle_cnt++;
    end
    $display("** response_frame_checker_top: FAILED **");
    $finish;
  end

  initial begin
    int p;
    logic [7:0] cmd_val, cap_val;
    rst_n = 1'b0;
    byte_if.valid = 1'b0;
    byte_if.rx_byte = 8'h00;
    byte_if.frame_start = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // idle byte, not ready, bad sync, restart mid-frame then too long,
    // length below two, and one good frame at reset config
    dir_tbl = '{
      '{8'h55, 1'b0, 1'b0, NO_RES},
      '{8'hFE, 1'b1, 1'b1, closing_result(STS_NOT_READY)},
      '{8'h01, 1'b1, 1'b0, NO_RES},
      '{8'hA5, 1'b0, 1'b1, closing_result(STS_BAD_HDR)},
      '{8'h01, 1'b1, 1'b0, NO_RES},
      '{8'h00, 1'b0, 1'b0, NO_RES},
      '{8'h81, 1'b1, 1'b0, NO_RES},
      '{8'h00, 1'b0, 1'b0, NO_RES},
      '{8'h00, 1'b0, 1'b0, NO_RES},
      '{8'hFF, 1'b0, 1'b0, NO_RES},
      '{8'h39, 1'b0, 1'b1, closing_result(STS_TOO_LONG)},
      '{8'h03, 1'b1, 1'b0, NO_RES},
      '{8'h00, 1'b0, 1'b0, NO_RES},
      '{8'h00, 1'b0, 1'b0, NO_RES},
      '{8'hFF, 1'b0, 1'b0, NO_RES},
      '{8'h01, 1'b0, 1'b1, closing_result(STS_BAD_HDR)},
      '{8'hFF, 1'b1, 1'b0, NO_RES},
      '{8'h00, 1'b0, 1'b0, NO_RES},
      '{8'h00, 1'b0, 1'b0, NO_RES},
      '{8'hFF, 1'b0, 1'b0, NO_RES},
      '{8'h03, 1'b0, 1'b0, NO_RES},
      '{8'hFD, 1'b0, 1'b0, NO_RES},
      '{8'hD5, 1'b0, 1'b0, NO_RES},
      '{8'h01, 1'b0, 1'b0, NO_RES},
      '{8'hFF, 1'b0, 1'b1, '{8'hFF, 1'b1, 1'b0, STS_OK}},
      '{8'h2B, 1'b0, 1'b1, closing_result(STS_OK)}
    };
    foreach (dir_tbl[i]) send(dir_tbl[i].data, dir_tbl[i].sof, dir_tbl[i].known, dir_tbl[i].want);

    for (p = 0; p < 5; p++) begin
      drain();
      case (p)
        0: begin cmd_val = 8'hFF; cap_val = 8'h00; end
        1: begin cmd_val = 8'($urandom); cap_val = 8'($urandom_range(1, 20)); end
        2: begin cmd_val = 8'($urandom); cap_val = 8'hFF; end
        3: begin cmd_val = 8'h00; cap_val = 8'(PAY_CEIL); end
        default: begin cmd_val = 8'($urandom); cap_val = 8'($urandom); end
      endcase
      write_reg(REG_EXP_CMD, cmd_val);
      write_reg(REG_CAPACITY, cap_val);
      if (p == 2) hold_req = 1'b1;
      while (useful_cnt < (p + 1) * PHASE_ITEMS) random_frame(1'b1);
      random_frame(1'b0);
    end
    drain();

    if (fail_cnt == 0) $display("** response_frame_checker_top: PASSED **");
    else $display("** response_frame_checker_top: FAILED **");
    $finish;
  end

endmodule
